// ----- rtl/asnap_pkg.sv -----
package asnap_pkg;

  localparam int unsigned MaxTargets = 64;
  localparam int unsigned CoordBits  = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  // Pixel window threshold in mm units: (window << 16) / pixels_per_mm.
  localparam int unsigned QuoW       = 33;
  localparam int unsigned DenW       = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SNAP_EN    = 3'd0,
    REG_EDGE_ON    = 3'd1,
    REG_CENTER_ON  = 3'd2,
    REG_CONTACT_ON = 3'd3,
    REG_SENS       = 3'd4,
    REG_STRENGTH   = 3'd5,
    REG_PPM        = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    logic                        opcode;
    logic [5:0]                  target_index;
    logic signed [CoordBits-1:0] box_min_x;
    logic signed [CoordBits-1:0] box_min_y;
    logic signed [CoordBits-1:0] box_max_x;
    logic signed [CoordBits-1:0] box_max_y;
    logic signed [CoordBits-1:0] delta_x;
    logic signed [CoordBits-1:0] delta_y;
    logic [6:0]                  target_count;
  } snap_in_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] corrected_dx;
    logic signed [CoordBits-1:0] corrected_dy;
    logic                        engaged_x;
    logic                        engaged_y;
  } snap_out_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] min_x;
    logic signed [CoordBits-1:0] min_y;
    logic signed [CoordBits-1:0] max_x;
    logic signed [CoordBits-1:0] max_y;
  } box_t;

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    mag34 = v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic signed [CoordBits-1:0] sat32(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sh0_7FFF_FFFF;
    lo = -hi - 35'sd1;
    if (v > hi) begin
      sat32 = hi[31:0];
    end else if (v < lo) begin
      sat32 = lo[31:0];
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- rtl/asnap_tbl.sv -----
module asnap_tbl #(
  parameter int unsigned Depth = asnap_pkg::MaxTargets,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  asnap_pkg::box_t  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output asnap_pkg::box_t  rdata_o
);
  import asnap_pkg::*;

  box_t mem [Depth];
  box_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/asnap_div.sv -----
module asnap_div (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [1:0][asnap_pkg::QuoW-1:0]         num_i,
  input  logic [asnap_pkg::DenW-1:0]              den_i,
  output logic                                    busy_o,
  output logic [1:0][asnap_pkg::QuoW-1:0]         quo_o
);
  import asnap_pkg::*;

  localparam int unsigned CntW = $clog2(QuoW + 1);

  logic [1:0][QuoW-1:0] quo_q, quo_d;
  logic [1:0][DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0]      den_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic [DenW:0]        rem_sh [2];

  // One restoring step per cycle on both lanes.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rem_sh[l] = {rem_q[l], quo_q[l][QuoW-1]};
      quo_d[l]  = {quo_q[l][QuoW-2:0], 1'b0};
      rem_d[l]  = rem_sh[l][DenW-1:0];
      if (rem_sh[l] >= {1'b0, den_q}) begin
        rem_d[l]    = DenW'(rem_sh[l] - {1'b0, den_q});
        quo_d[l][0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(QuoW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/alignment_snap_with_hysteresis.sv -----
// Load transaction: result strobe in the cycle after start is taken, busy_o never rises.
// Bypassed query (snapping off, zero count or zero scale): result in the cycle after start is taken.
// Snap query: result strobe once the table scan and the divider are both done; the table scan reads
// one entry per cycle and overlaps a 33-step divider that turns both windows into mm limits.
// One transaction in flight; results are strobed on done_o and cannot be stalled.
// Reset clears configuration to defaults and engaged state; the target table is not cleared.
module alignment_snap_with_hysteresis #(
  parameter int unsigned MAX_TARGETS = asnap_pkg::MaxTargets
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  asnap_pkg::snap_in_t               in_i,
  output logic                              done_o,
  output asnap_pkg::snap_out_t              out_o,
  input  logic                              cfg_we_i,
  input  logic [asnap_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [asnap_pkg::CfgDataW-1:0]    cfg_data_i
);
  import asnap_pkg::*;

  localparam int unsigned AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned CW = $clog2(MAX_TARGETS + 1);

  // Configuration registers.
  logic        snap_en_q, edge_on_q, center_on_q, contact_on_q;
  logic [15:0] sens_q, str_q, ppm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_en_q    <= 1'b0;
      edge_on_q    <= 1'b1;
      center_on_q  <= 1'b1;
      contact_on_q <= 1'b1;
      sens_q       <= 16'd2560;
      str_q        <= 16'd1280;
      ppm_q        <= 16'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SNAP_EN:    snap_en_q    <= cfg_data_i[0];
        REG_EDGE_ON:    edge_on_q    <= cfg_data_i[0];
        REG_CENTER_ON:  center_on_q  <= cfg_data_i[0];
        REG_CONTACT_ON: contact_on_q <= cfg_data_i[0];
        REG_SENS:       sens_q       <= cfg_data_i;
        REG_STRENGTH:   str_q        <= cfg_data_i;
        REG_PPM:        ppm_q        <= cfg_data_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Accept and classify the incoming transaction.
  state_e        state_q, state_d;
  logic          accept, is_load, bypass, div_start, load_we;
  logic [CW-1:0] cnt_sat;

  assign accept  = start_i && !busy_o;
  assign is_load = (in_i.opcode == OP_LOAD);
  assign cnt_sat = (int'(in_i.target_count) > int'(MAX_TARGETS)) ? CW'(MAX_TARGETS)
                                                                 : CW'(in_i.target_count);
  assign bypass  = !snap_en_q || (cnt_sat == '0) || (ppm_q == '0);
  assign div_start = accept && !is_load && !bypass;
  assign load_we   = accept && is_load && (int'(in_i.target_index) < int'(MAX_TARGETS));

  // Moved mover keys and the hold candidate, computed at accept.
  logic signed [32:0] mlo_d [2], mhi_d [2], kc_d [2];
  logic signed [33:0] ksum  [2];
  logic signed [31:0] dlt   [2];
  logic signed [31:0] bmin  [2], bmax [2];
  logic signed [33:0] hc    [3];
  logic signed [33:0] hbest_d [2];
  logic signed [33:0] lext;

  assign bmin[0] = in_i.box_min_x;
  assign bmin[1] = in_i.box_min_y;
  assign bmax[0] = in_i.box_max_x;
  assign bmax[1] = in_i.box_max_y;
  assign dlt[0]  = in_i.delta_x;
  assign dlt[1]  = in_i.delta_y;

  logic signed [31:0] line_q [2], line_d [2];
  logic [1:0]         eng_st_q, eng_st_d;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mlo_d[a] = {bmin[a][31], bmin[a]} + {dlt[a][31], dlt[a]};
      mhi_d[a] = {bmax[a][31], bmax[a]} + {dlt[a][31], dlt[a]};
      ksum[a]  = {mlo_d[a][32], mlo_d[a]} + {mhi_d[a][32], mhi_d[a]};
      kc_d[a]  = ksum[a][33:1];
      lext     = {{2{line_q[a][31]}}, line_q[a]};
      hc[0]    = lext - {mlo_d[a][32], mlo_d[a]};
      hc[1]    = lext - {mhi_d[a][32], mhi_d[a]};
      hc[2]    = lext - {kc_d[a][32], kc_d[a]};
      hbest_d[a] = hc[0];
      for (int k = 1; k < 3; k++) begin
        if (mag34(hc[k]) < mag34(hbest_d[a])) begin
          hbest_d[a] = hc[k];
        end
      end
    end
  end

  logic signed [32:0] mlo_q [2], mhi_q [2], kc_q [2];
  logic signed [33:0] hbest_q [2];
  logic signed [31:0] dlt_q [2];
  logic [CW-1:0]      cnt_q, issue_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      for (int a = 0; a < 2; a++) begin
        mlo_q[a]   <= mlo_d[a];
        mhi_q[a]   <= mhi_d[a];
        kc_q[a]    <= kc_d[a];
        hbest_q[a] <= hbest_d[a];
        dlt_q[a]   <= dlt[a];
      end
      cnt_q <= cnt_sat;
    end
  end

  // Target table and window divider.
  logic  rd_en;
  box_t  wbox, rbox;
  logic  div_busy;
  logic [1:0][QuoW-1:0] div_num, quo;
  logic [16:0]          win_sum;

  assign wbox.min_x = in_i.box_min_x;
  assign wbox.min_y = in_i.box_min_y;
  assign wbox.max_x = in_i.box_max_x;
  assign wbox.max_y = in_i.box_max_y;
  assign rd_en      = (state_q == ST_RUN) && (issue_q < cnt_q);

  asnap_tbl #(
    .Depth (MAX_TARGETS),
    .AddrW (AW)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(in_i.target_index)),
    .wdata_i (wbox),
    .re_i    (rd_en),
    .raddr_i (issue_q[AW-1:0]),
    .rdata_o (rbox)
  );

  // Lane 0: capture window; lane 1: break-away window.
  assign win_sum    = {1'b0, sens_q} + {1'b0, str_q};
  assign div_num[0] = {1'b0, sens_q, 16'h0};
  assign div_num[1] = {win_sum, 16'h0};

  asnap_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (ppm_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // Candidate evaluation on the entry read last cycle. The nearest candidate is tracked
  // by magnitude alone; the window test happens once the limits are known.
  logic signed [31:0] tlo [2], thi [2];
  logic signed [32:0] tsum [2];
  logic signed [33:0] cc [2][5];
  logic signed [31:0] ct [2][5];
  logic               cen [2][5];
  logic               contact_ok [2];
  logic [1:0]         found_q, found_d;
  logic [33:0]        bmag_q [2], bmag_d [2];
  logic signed [33:0] bcorr_q [2], bcorr_d [2];
  logic signed [31:0] bline_q [2], bline_d [2];

  assign tlo[0] = rbox.min_x;
  assign tlo[1] = rbox.min_y;
  assign thi[0] = rbox.max_x;
  assign thi[1] = rbox.max_y;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      tsum[a] = {tlo[a][31], tlo[a]} + {thi[a][31], thi[a]};
      contact_ok[a] = (mlo_q[1-a] < $signed({thi[1-a][31], thi[1-a]})) &&
                      ($signed({tlo[1-a][31], tlo[1-a]}) < mhi_q[1-a]);
      ct[a][0] = tlo[a];
      ct[a][1] = thi[a];
      ct[a][2] = tsum[a][32:1];
      ct[a][3] = tlo[a];
      ct[a][4] = thi[a];
      cc[a][0] = {{2{tlo[a][31]}}, tlo[a]} - {mlo_q[a][32], mlo_q[a]};
      cc[a][1] = {{2{thi[a][31]}}, thi[a]} - {mhi_q[a][32], mhi_q[a]};
      cc[a][2] = {{2{tsum[a][32]}}, tsum[a][32:1]} - {kc_q[a][32], kc_q[a]};
      cc[a][3] = {{2{tlo[a][31]}}, tlo[a]} - {mhi_q[a][32], mhi_q[a]};
      cc[a][4] = {{2{thi[a][31]}}, thi[a]} - {mlo_q[a][32], mlo_q[a]};
      cen[a][0] = edge_on_q;
      cen[a][1] = edge_on_q;
      cen[a][2] = center_on_q;
      cen[a][3] = contact_on_q && contact_ok[a];
      cen[a][4] = contact_on_q && contact_ok[a];
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      found_d[a] = found_q[a];
      bmag_d[a]  = bmag_q[a];
      bcorr_d[a] = bcorr_q[a];
      bline_d[a] = bline_q[a];
      for (int i = 0; i < 5; i++) begin
        // Strictly nearer only: the earliest candidate keeps a tie.
        if (rd_vld_q && cen[a][i] && (!found_d[a] || (mag34(cc[a][i]) < bmag_d[a]))) begin
          found_d[a] = 1'b1;
          bmag_d[a]  = mag34(cc[a][i]);
          bcorr_d[a] = cc[a][i];
          bline_d[a] = ct[a][i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
    end else if (div_start) begin
      found_q  <= '0;
      issue_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      found_q  <= found_d;
      rd_vld_q <= rd_en;
      if (rd_en) begin
        issue_q <= issue_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      bmag_q[a]  <= bmag_d[a];
      bcorr_q[a] <= bcorr_d[a];
      bline_q[a] <= bline_d[a];
    end
  end

  // Resolve each axis: hold first, then the best search candidate.
  logic               finish;
  logic               hold_ok [2], srch_ok [2];
  logic signed [34:0] fsum [2];
  logic signed [31:0] fcorr [2];
  logic [1:0]         feng;

  assign finish = (state_q == ST_RUN) && (issue_q == cnt_q) && !rd_vld_q && !div_busy;

  always_comb begin
    eng_st_d = eng_st_q;
    for (int a = 0; a < 2; a++) begin
      line_d[a]  = line_q[a];
      hold_ok[a] = eng_st_q[a] && (mag34(hbest_q[a]) <= 34'(quo[1]));
      srch_ok[a] = found_q[a] && (bmag_q[a] <= 34'(quo[0]));
      fsum[a]    = {{3{dlt_q[a][31]}}, dlt_q[a]};
      feng[a]    = 1'b0;
      if (hold_ok[a]) begin
        fsum[a] = {{3{dlt_q[a][31]}}, dlt_q[a]} + {hbest_q[a][33], hbest_q[a]};
        feng[a] = 1'b1;
      end else if (srch_ok[a]) begin
        fsum[a] = {{3{dlt_q[a][31]}}, dlt_q[a]} + {bcorr_q[a][33], bcorr_q[a]};
        feng[a] = 1'b1;
      end
      if (!hold_ok[a]) begin
        eng_st_d[a] = srch_ok[a];
        if (srch_ok[a]) begin
          line_d[a] = bline_q[a];
        end
      end
      fcorr[a] = sat32(fsum[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_st_q <= '0;
      line_q[0] <= '0;
      line_q[1] <= '0;
    end else if (finish) begin
      eng_st_q <= eng_st_d;
      line_q[0] <= line_d[0];
      line_q[1] <= line_d[1];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (div_start) state_d = ST_RUN;
      ST_RUN:  if (finish) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register: strobe for one cycle.
  logic      done_q;
  snap_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (accept && (is_load || bypass)) || finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_load) begin
      out_q <= '0;
    end else if (accept && bypass) begin
      out_q.corrected_dx <= in_i.delta_x;
      out_q.corrected_dy <= in_i.delta_y;
      out_q.engaged_x    <= 1'b0;
      out_q.engaged_y    <= 1'b0;
    end else if (finish) begin
      out_q.corrected_dx <= fcorr[0];
      out_q.corrected_dy <= fcorr[1];
      out_q.engaged_x    <= feng[0];
      out_q.engaged_y    <= feng[1];
    end
  end

  assign done_o = done_q;
  assign out_o  = out_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobed while a query is running");

  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> busy_o && div_busy) else $error("query did not start the scan");

  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (issue_q <= cnt_q)) else $error("scan ran past the target count");

  a_finish_once : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> !busy_o && done_o) else $error("finish did not retire the query");

endmodule

// ----- tb/sv/tb_alignment_snap_with_hysteresis.sv -----
module tb_alignment_snap_with_hysteresis;
  import asnap_pkg::*;

  // Kinds of work the driver pulls from its pending queue.
  typedef enum logic [1:0] {
    JOB_ITEM,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e   kind;
    snap_in_t    item;
    cfg_reg_e    cidx;
    logic [15:0] cval;
  } job_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  snap_in_t            in_i = '0;
  logic                done_o;
  snap_out_t           out_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  alignment_snap_with_hysteresis dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .in_i      (in_i),
    .done_o    (done_o),
    .out_o     (out_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending stimulus and the snap results still owed by the block.
  job_t      job_q[$];
  snap_out_t snap_due_q[$];

  // Mirror of the configuration registers, reset values included.
  bit          snap_on = 1'b0;
  bit          edge_on = 1'b1;
  bit          center_on = 1'b1;
  bit          contact_on = 1'b1;
  bit [15:0]   sens_px = 16'd2560;
  bit [15:0]   margin_px = 16'd1280;
  bit [15:0]   scale_q88 = 16'd1024;

  // Mirror of the target table and the hysteresis state.
  longint      tgt_min[MaxTargets][2];
  longint      tgt_max[MaxTargets][2];
  bit [1:0]    held_axis = 2'b00;
  longint      held_line[2] = '{0, 0};

  bit          took = 1'b0;
  int          gap = 0;
  bit          quiet = 1'b0;
  int          fails = 0;
  int          n_loads = 0;
  int          n_queries = 0;
  int          n_engaged = 0;
  int          n_cfg = 0;

  function automatic longint absv(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Floor of v / 2, also for negative v.
  function automatic longint half_dn(longint v);
    return v >>> 1;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Work out the snap result of one accepted transaction and advance the mirrored state.
  function automatic snap_out_t snap_predict(snap_in_t it);
    snap_out_t r;
    longint    lo[2], hi[2], dl[2], corr[2], keys[3], pk[5], pt[5];
    longint    c, bc, d, bestd, win, bestc, bestline, line;
    int        cnt, p, np;
    bit        found, kept;
    bit        eng[2];
    r = '0;
    if (it.opcode == OP_LOAD) begin
      tgt_min[it.target_index][0] = it.box_min_x;
      tgt_min[it.target_index][1] = it.box_min_y;
      tgt_max[it.target_index][0] = it.box_max_x;
      tgt_max[it.target_index][1] = it.box_max_y;
      return r;
    end
    lo[0] = it.box_min_x; lo[1] = it.box_min_y;
    hi[0] = it.box_max_x; hi[1] = it.box_max_y;
    dl[0] = it.delta_x;   dl[1] = it.delta_y;
    corr = dl;
    eng = '{0, 0};
    cnt = (it.target_count > MaxTargets) ? MaxTargets : int'(it.target_count);
    if (snap_on && cnt != 0 && scale_q88 != 0) begin
      for (int a = 0; a < 2; a++) begin
        lo[a] += dl[a];
        hi[a] += dl[a];
      end
      for (int a = 0; a < 2; a++) begin
        p = 1 - a;
        keys[0] = lo[a];
        keys[1] = hi[a];
        keys[2] = half_dn(lo[a] + hi[a]);
        kept = 1'b0;
        // Hold an engaged axis while the nearest key stays inside the break-away window.
        if (held_axis[a]) begin
          line = held_line[a];
          bc = line - keys[0];
          for (int k = 1; k < 3; k++)
            if (absv(line - keys[k]) < absv(bc)) bc = line - keys[k];
          if (absv(bc) * longint'(scale_q88) <=
              ((longint'(sens_px) + longint'(margin_px)) << 16)) begin
            corr[a] += bc;
            eng[a] = 1'b1;
            kept = 1'b1;
          end else begin
            held_axis[a] = 1'b0;
          end
        end
        if (!kept) begin
          found = 1'b0;
          bestd = 0;
          bestc = 0;
          bestline = 0;
          win = longint'(sens_px) << 16;
          for (int n = 0; n < cnt; n++) begin
            np = 0;
            if (edge_on) begin
              pk[np] = keys[0]; pt[np] = tgt_min[n][a]; np++;
              pk[np] = keys[1]; pt[np] = tgt_max[n][a]; np++;
            end
            if (center_on) begin
              pk[np] = keys[2]; pt[np] = half_dn(tgt_min[n][a] + tgt_max[n][a]); np++;
            end
            // Touching edges only count when the boxes strictly overlap on the other axis.
            if (contact_on && lo[p] < tgt_max[n][p] && tgt_min[n][p] < hi[p]) begin
              pk[np] = keys[1]; pt[np] = tgt_min[n][a]; np++;
              pk[np] = keys[0]; pt[np] = tgt_max[n][a]; np++;
            end
            for (int i = 0; i < np; i++) begin
              c = pt[i] - pk[i];
              d = absv(c) * longint'(scale_q88);
              if (d <= win && (!found || d < bestd)) begin
                found = 1'b1;
                bestd = d;
                bestc = c;
                bestline = pt[i];
              end
            end
          end
          if (found) begin
            corr[a] += bestc;
            eng[a] = 1'b1;
            held_axis[a] = 1'b1;
            held_line[a] = bestline;
          end
        end
      end
    end
    r.corrected_dx = clip32(corr[0]);
    r.corrected_dy = clip32(corr[1]);
    r.engaged_x = eng[0];
    r.engaged_y = eng[1];
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and stretches with none at all.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 59) == 0) quiet = ~quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int near_mm();
    return int'($urandom_range(0, 400 * 65536)) - 200 * 65536;
  endfunction

  function automatic int wild_coord();
    case ($urandom_range(0, 3))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Fill the box fields: mostly small ordered boxes, sometimes anything at all.
  function automatic snap_in_t put_box(snap_in_t it);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      it.box_min_x = near_mm();
      it.box_min_y = near_mm();
      it.box_max_x = it.box_min_x + int'($urandom_range(0, 40 * 65536));
      it.box_max_y = it.box_min_y + int'($urandom_range(0, 40 * 65536));
    end else if (r < 92) begin
      it.box_min_x = $urandom;
      it.box_min_y = $urandom;
      it.box_max_x = $urandom;
      it.box_max_y = $urandom;
    end else begin
      it.box_min_x = wild_coord();
      it.box_min_y = wild_coord();
      it.box_max_x = wild_coord();
      it.box_max_y = wild_coord();
    end
    return it;
  endfunction

  function automatic logic [6:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 82) return 7'($urandom_range(1, 64));
    if (r < 92) return 7'($urandom_range(65, 127));
    return 7'd0;
  endfunction

  task automatic add_item(snap_in_t it);
    job_t j;
    j.kind = JOB_ITEM;
    j.item = it;
    j.cidx = REG_SNAP_EN;
    j.cval = '0;
    job_q.push_back(j);
  endtask

  task automatic add_load(int idx);
    snap_in_t it;
    it = put_box('0);
    it.opcode = OP_LOAD;
    it.target_index = 6'(idx);
    it.delta_x = $urandom;
    it.delta_y = $urandom;
    it.target_count = 7'($urandom);
    add_item(it);
  endtask

  task automatic add_query(int mnx, int mny, int mxx, int mxy, int dx, int dy,
                           logic [6:0] cnt);
    snap_in_t it;
    it.opcode = OP_QUERY;
    it.target_index = 6'($urandom);
    it.box_min_x = mnx;
    it.box_min_y = mny;
    it.box_max_x = mxx;
    it.box_max_y = mxy;
    it.delta_x = dx;
    it.delta_y = dy;
    it.target_count = cnt;
    add_item(it);
  endtask

  // Write every register; the driver holds each write until the block is idle.
  task automatic add_setting(bit en, bit ed, bit ce, bit co, int sn, int st, int pp);
    job_t     j;
    int       v[7];
    cfg_reg_e idx[7];
    v = '{en, ed, ce, co, sn, st, pp};
    idx = '{REG_SNAP_EN, REG_EDGE_ON, REG_CENTER_ON, REG_CONTACT_ON,
            REG_SENS, REG_STRENGTH, REG_PPM};
    for (int i = 0; i < 7; i++) begin
      j.kind = JOB_CFG;
      j.item = '0;
      j.cidx = idx[i];
      j.cval = 16'(v[i]);
      job_q.push_back(j);
    end
  endtask

  task automatic add_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.item = '0;
    j.cidx = REG_SNAP_EN;
    j.cval = '0;
    job_q.push_back(j);
  endtask

  // A drag: one mover, a delta that creeps in small steps, so the hysteresis gets exercised.
  task automatic add_drag();
    snap_in_t   b;
    int         dx, dy, len;
    logic [6:0] cnt;
    b = put_box('0);
    if ($urandom_range(0, 9) != 0) begin
      b.box_min_x = near_mm();
      b.box_min_y = near_mm();
      b.box_max_x = b.box_min_x + int'($urandom_range(0, 40 * 65536));
      b.box_max_y = b.box_min_y + int'($urandom_range(0, 40 * 65536));
    end
    dx = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
    dy = int'($urandom_range(0, 20 * 65536)) - 10 * 65536;
    cnt = pick_count();
    len = $urandom_range(3, 12);
    for (int i = 0; i < len; i++) begin
      add_query(b.box_min_x, b.box_min_y, b.box_max_x, b.box_max_y, dx, dy, cnt);
      dx += int'($urandom_range(0, 65536)) - 32768;
      dy += int'($urandom_range(0, 65536)) - 32768;
    end
  endtask

  task automatic add_noise_query();
    snap_in_t it;
    it = put_box('0);
    it.opcode = OP_QUERY;
    it.target_index = 6'($urandom);
    it.delta_x = $urandom;
    it.delta_y = $urandom;
    it.target_count = 7'($urandom);
    add_item(it);
  endtask

  task automatic add_random_phase(int n_items);
    int made, r;
    made = 0;
    while (made < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        add_load($urandom_range(0, 63));
        made++;
      end else if (r < 85) begin
        add_drag();
        made += 7;
      end else if (r < 97) begin
        add_noise_query();
        made++;
      end else begin
        add_drain();
      end
    end
  endtask

  // Driver: present transactions at the falling edge, hold each until it is taken.
  always @(negedge clk_i) begin : drive
    logic        nstart;
    logic        nwe;
    snap_in_t    nin;
    nstart = start_i;
    nwe = 1'b0;
    nin = in_i;
    if (rst_ni && !(start_i && !took)) begin
      nstart = 1'b0;
      if (gap > 0) begin
        gap--;
      end else if (job_q.size() > 0) begin
        case (job_q[0].kind)
          JOB_ITEM: begin
            nstart = 1'b1;
            nin = job_q[0].item;
            void'(job_q.pop_front());
            gap = pick_gap();
          end
          JOB_CFG: begin
            if (snap_due_q.size() == 0 && !busy_o) begin
              nwe = 1'b1;
              cfg_idx_i <= job_q[0].cidx;
              cfg_data_i <= job_q[0].cval;
              void'(job_q.pop_front());
            end
          end
          default: begin
            if (snap_due_q.size() == 0) void'(job_q.pop_front());
          end
        endcase
      end
    end
    start_i <= nstart;
    in_i <= nin;
    cfg_we_i <= nwe;
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  // Monitor: check results first, then mirror register writes and take new transactions.
  always @(posedge clk_i) begin : watch
    snap_out_t w;
    snap_out_t p;
    took = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (snap_due_q.size() == 0) begin
          $display("%0t result with nothing expected: actual %h", $time, out_o);
          fails++;
        end else begin
          w = snap_due_q.pop_front();
          check_field("corrected_dx", w.corrected_dx, out_o.corrected_dx);
          check_field("corrected_dy", w.corrected_dy, out_o.corrected_dy);
          check_field("engaged_x", 32'(w.engaged_x), 32'(out_o.engaged_x));
          check_field("engaged_y", 32'(w.engaged_y), 32'(out_o.engaged_y));
        end
      end
      if (cfg_we_i) begin
        n_cfg++;
        case (cfg_reg_e'(cfg_idx_i))
          REG_SNAP_EN:    snap_on = cfg_data_i[0];
          REG_EDGE_ON:    edge_on = cfg_data_i[0];
          REG_CENTER_ON:  center_on = cfg_data_i[0];
          REG_CONTACT_ON: contact_on = cfg_data_i[0];
          REG_SENS:       sens_px = cfg_data_i;
          REG_STRENGTH:   margin_px = cfg_data_i;
          REG_PPM:        scale_q88 = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        took = 1'b1;
        p = snap_predict(in_i);
        if (in_i.opcode == OP_LOAD) n_loads++;
        else n_queries++;
        if (p.engaged_x || p.engaged_y) n_engaged++;
        snap_due_q.push_back(p);
      end
    end
  end

  initial begin : limit
    #20_000_000;
    $display("timeout with %0d results outstanding", snap_due_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    int wait_cyc;
    // Fill the whole table first so that any count may be queried.
    for (int i = 0; i < MaxTargets; i++) add_load(i);
    add_setting(1, 1, 1, 1, 2560, 1280, 1024);

    // Directed: saturation both ways through an edge snap, then hold it.
    add_item('{opcode: OP_LOAD, target_index: 6'd0, box_min_x: 32'sh1000_0000,
               box_min_y: 0, box_max_x: 32'sh1001_0000, box_max_y: 32'sh0001_0000,
               delta_x: 0, delta_y: 0, target_count: 0});
    add_query(-32'sh7000_7FFF, 0, -32'sh6FFF_7FFF, 32'sh0001_0000,
              32'sh7FFF_FFFF, 0, 7'd1);
    add_query(-32'sh7000_7FFF, 0, -32'sh6FFF_7FFF, 32'sh0001_0000,
              32'sh7FFF_FFFF, 0, 7'd1);
    add_item('{opcode: OP_LOAD, target_index: 6'd63, box_min_x: -32'sh1001_0000,
               box_min_y: 0, box_max_x: -32'sh1000_0000, box_max_y: 32'sh0001_0000,
               delta_x: 32'sh7FFF_FFFF, delta_y: 32'sh8000_0000, target_count: 7'd127});
    add_query(32'sh6FFF_8000, 0, 32'sh7000_8000, 32'sh0001_0000,
              32'sh8000_0000, 0, 7'd127);
    // Zero count passes through; extremes of every field.
    add_query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, 7'd0);
    add_query(-1, -1, -1, -1, -1, -1, 7'd127);
    add_query(0, 0, 0, 0, 0, 0, 7'd64);
    // A drag that engages, creeps inside the window, then breaks away.
    for (int i = 0; i < 8; i++)
      add_query(32'sh1000_0000, 0, 32'sh1001_0000, 32'sh0001_0000, i * 32'sh0001_0000,
                0, 7'd1);
    add_load(0);
    add_load(63);
    add_drain();

    add_setting(1, 1, 1, 1, 2560, 1280, 1024);
    add_random_phase(180);
    add_setting(1, 1, 0, 0, 65535, 0, 65535);
    add_random_phase(160);
    add_setting(1, 0, 1, 0, 0, 65535, 1);
    add_random_phase(160);
    add_setting(1, 0, 0, 1, 5000, 3000, 256);
    add_random_phase(160);
    add_setting(0, 1, 1, 1, 2560, 1280, 1024);
    add_random_phase(120);
    add_setting(1, 1, 1, 1, 2560, 1280, 0);
    add_random_phase(120);
    add_setting(1, 1, 1, 1, 40000, 20000, 4000);
    add_random_phase(160);
    add_setting(1, 0, 0, 0, 2560, 1280, 1024);
    add_random_phase(120);
    add_setting(1, 1, 1, 1, 0, 0, 65535);
    add_random_phase(120);

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain everything, then allow for the longest scan.
    while (job_q.size() > 0 || start_i || snap_due_q.size() > 0) @(posedge clk_i);
    wait_cyc = 0;
    while (wait_cyc < 3 * MaxTargets) begin
      @(posedge clk_i);
      wait_cyc++;
    end

    $display("covered %0d loads and %0d queries (%0d snapped) over %0d register writes",
             n_loads, n_queries, n_engaged, n_cfg);
    $display("%0d mismatches or stray results", fails);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/asnap_pkg.sv
rtl/asnap_tbl.sv
rtl/asnap_div.sv
rtl/alignment_snap_with_hysteresis.sv
tb/sv/tb_alignment_snap_with_hysteresis.sv
